### design/dbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// dbc_pkg: shared types, codes and constants of the 2-D density clustering block.
// No dependencies.
package dbc_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int COORD_W = 16;
  localparam int LABEL_W = 11;
  localparam int EPS_W   = 33;
  localparam int CNT_W   = 11;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD = 2'd0;
  localparam op_t OP_RUN  = 2'd1;
  localparam op_t OP_READ = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_EPS    = 2'd0;
  localparam cfg_idx_t CFG_MINP   = 2'd1;
  localparam cfg_idx_t CFG_NPOINT = 2'd2;

  localparam logic [EPS_W-1:0] EPS_RESET  = 33'd65536;
  localparam logic [CNT_W-1:0] MINP_RESET = 11'd5;
  localparam logic [CNT_W-1:0] NPTS_RESET = 11'd1024;

  localparam logic [LABEL_W-1:0] LABEL_NONE  = '0;
  localparam logic [LABEL_W-1:0] LABEL_NOISE = '1;

  typedef struct packed {
    op_t                        op;
    logic [9:0]                 index;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
  } in_word_t;

  typedef struct packed {
    logic signed [11:0]  label;
    logic [CNT_W-1:0]    cluster_count;
    logic [CNT_W-1:0]    noise_count;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FINISH,
    ST_RUN_NEXT,
    ST_RUN_LBL,
    ST_SW_ADDR,
    ST_SW_DATA,
    ST_SW_SQ1,
    ST_SW_SQ2,
    ST_SW_CMP,
    ST_SEED_NEXT,
    ST_SEED_Q,
    ST_SEED_L,
    ST_NZ_ADDR,
    ST_NZ_DATA
  } state_t;

  typedef enum logic {SW_COUNT, SW_ADD} sweep_mode_t;
  typedef enum logic {CTX_OUTER, CTX_SEED} ctx_t;

endpackage
`default_nettype wire

### design/dbc_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// dbc_chan_if: valid/ready channel carrying one word of a given payload type.
// No dependencies.
interface dbc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/dbc_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// dbc_cfg_if: register write channel, index and data with valid/ready.
// Depends on dbc_pkg.
interface dbc_cfg_if;
  logic                        valid;
  logic                        ready;
  dbc_pkg::cfg_idx_t           index;
  logic [dbc_pkg::EPS_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### design/dbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// dbc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/dbc_sq.sv
`timescale 1ns / 1ps
`default_nettype none
// dbc_sq: shared registered squarer for coordinate differences.
// No dependencies.
module dbc_sq (
  input  wire logic               clk,
  input  wire logic signed [16:0] a,
  output logic [31:0]             sq
);
  logic signed [33:0] prod;

  assign prod = a * a;

  always_ff @(posedge clk) begin
    sq <= prod[31:0];
  end
endmodule
`default_nettype wire

### design/density_clustering_2d.sv
`timescale 1ns / 1ps
`default_nettype none
// density_clustering_2d: top level, sequencer of the DBSCAN clustering block.
// Depends on dbc_pkg, dbc_chan_if, dbc_cfg_if, dbc_ram and dbc_sq.
//
// Load words with an index in range are written as they are accepted; a read
// word's label is valid on the result channel from the clock edge after the
// accepting one. A result word still waiting on the result channel holds the
// input off. After reset, and at the start of every run, a clearing pass over
// all MAX_POINTS entries wipes the label and seed-mark memories. A run then
// visits points in index order; each neighbour sweep (the core count, and each
// seed-list extension) steps through the N active points one at a time, through
// the single shared squarer and the one read port of the coordinate memories,
// so the time of a run grows quadratically in N. Configuration writes are
// always taken, and must only be issued while idle.
module density_clustering_2d #(
  parameter int MAX_POINTS = dbc_pkg::MAX_POINTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  dbc_chan_if.sink   items,
  dbc_chan_if.source results,
  dbc_cfg_if.sink    cfg
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = dbc_pkg::LABEL_W;

  dbc_pkg::state_t state, state_next;

  logic [dbc_pkg::EPS_W-1:0] eps_squared;
  logic [dbc_pkg::CNT_W-1:0] core_min;
  logic [dbc_pkg::CNT_W-1:0] point_count;

  logic [AW-1:0] clr;
  logic          run_pend;
  logic [CW-1:0] n_r, i, j, k, scount, cnt, noise;
  logic [LW-1:0] cur;
  logic [AW-1:0] q;
  logic signed [dbc_pkg::COORD_W-1:0] px, py;
  logic signed [16:0] dx, dy;
  logic [31:0]   sq1, sq;
  logic          mark_hit, rd_ok;
  dbc_pkg::sweep_mode_t mode;
  dbc_pkg::ctx_t        ctx;
  logic          out_valid;
  dbc_pkg::out_word_t out_data;

  logic          accept;
  logic          idx_ok;
  logic          core, near, sweep_end;
  logic [AW-1:0] idx_addr;

  logic          xy_we;
  logic [AW-1:0] xy_raddr;
  logic signed [dbc_pkg::COORD_W-1:0] x_rd, y_rd;
  logic          lbl_we;
  logic [AW-1:0] lbl_waddr, lbl_raddr;
  logic [LW-1:0] lbl_wdata, lbl_rd;
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  logic [LW-1:0] mark_wdata, mark_rd;
  logic          seed_we;
  logic [AW-1:0] seed_raddr;
  logic [AW-1:0] seed_rd;
  logic signed [16:0] sq_in;

  assign items.ready  = (state == dbc_pkg::ST_IDLE) && (!out_valid || results.ready);
  assign accept       = items.valid && items.ready;
  assign cfg.ready    = 1'b1;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  assign idx_ok    = 32'(items.data.index) < MAX_POINTS;
  assign idx_addr  = AW'(items.data.index);
  assign core      = 32'(cnt) >= 32'(core_min);
  assign near      = (33'(sq1) + 33'(sq)) <= eps_squared;
  assign sweep_end = (j == n_r);
  assign sq_in     = (state == dbc_pkg::ST_SW_SQ1) ? dx : dy;

  dbc_ram #(.WIDTH(dbc_pkg::COORD_W), .DEPTH(MAX_POINTS)) u_x (
    .clk, .we(xy_we), .waddr(idx_addr), .wdata(items.data.x_coord),
    .raddr(xy_raddr), .rdata(x_rd)
  );
  dbc_ram #(.WIDTH(dbc_pkg::COORD_W), .DEPTH(MAX_POINTS)) u_y (
    .clk, .we(xy_we), .waddr(idx_addr), .wdata(items.data.y_coord),
    .raddr(xy_raddr), .rdata(y_rd)
  );
  dbc_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_label (
    .clk, .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
    .raddr(lbl_raddr), .rdata(lbl_rd)
  );
  dbc_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_mark (
    .clk, .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(j[AW-1:0]), .rdata(mark_rd)
  );
  dbc_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_seed (
    .clk, .we(seed_we), .waddr(scount[AW-1:0]), .wdata(j[AW-1:0]),
    .raddr(seed_raddr), .rdata(seed_rd)
  );
  dbc_sq u_sq (.clk, .a(sq_in), .sq);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dbc_pkg::ST_CLEAR: begin
        if (clr == AW'(MAX_POINTS - 1)) begin
          state_next = run_pend ? dbc_pkg::ST_RUN_NEXT : dbc_pkg::ST_IDLE;
        end
      end
      dbc_pkg::ST_IDLE: begin
        if (accept && items.data.op == dbc_pkg::OP_RUN) begin
          state_next = dbc_pkg::ST_CLEAR;
        end else if (accept && items.data.op == dbc_pkg::OP_READ) begin
          state_next = dbc_pkg::ST_READ;
        end
      end
      dbc_pkg::ST_READ:   state_next = dbc_pkg::ST_IDLE;
      dbc_pkg::ST_FINISH: state_next = dbc_pkg::ST_IDLE;
      dbc_pkg::ST_RUN_NEXT: begin
        state_next = (i == n_r) ? dbc_pkg::ST_NZ_ADDR : dbc_pkg::ST_RUN_LBL;
      end
      dbc_pkg::ST_RUN_LBL: begin
        state_next = (lbl_rd != dbc_pkg::LABEL_NONE) ? dbc_pkg::ST_RUN_NEXT
                                                     : dbc_pkg::ST_SW_ADDR;
      end
      dbc_pkg::ST_SW_ADDR: begin
        if (!sweep_end) begin
          state_next = dbc_pkg::ST_SW_DATA;
        end else if (mode == dbc_pkg::SW_ADD) begin
          state_next = dbc_pkg::ST_SEED_NEXT;
        end else if (ctx == dbc_pkg::CTX_OUTER) begin
          state_next = core ? dbc_pkg::ST_SW_ADDR : dbc_pkg::ST_RUN_NEXT;
        end else begin
          state_next = core ? dbc_pkg::ST_SW_ADDR : dbc_pkg::ST_SEED_NEXT;
        end
      end
      dbc_pkg::ST_SW_DATA: state_next = dbc_pkg::ST_SW_SQ1;
      dbc_pkg::ST_SW_SQ1:  state_next = dbc_pkg::ST_SW_SQ2;
      dbc_pkg::ST_SW_SQ2:  state_next = dbc_pkg::ST_SW_CMP;
      dbc_pkg::ST_SW_CMP:  state_next = dbc_pkg::ST_SW_ADDR;
      dbc_pkg::ST_SEED_NEXT: begin
        state_next = (k == scount) ? dbc_pkg::ST_RUN_NEXT : dbc_pkg::ST_SEED_Q;
      end
      dbc_pkg::ST_SEED_Q: state_next = dbc_pkg::ST_SEED_L;
      dbc_pkg::ST_SEED_L: begin
        state_next = (lbl_rd == dbc_pkg::LABEL_NONE) ? dbc_pkg::ST_SW_ADDR
                                                     : dbc_pkg::ST_SEED_NEXT;
      end
      dbc_pkg::ST_NZ_ADDR: begin
        state_next = sweep_end ? dbc_pkg::ST_FINISH : dbc_pkg::ST_NZ_DATA;
      end
      dbc_pkg::ST_NZ_DATA: state_next = dbc_pkg::ST_NZ_ADDR;
      default:             state_next = dbc_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    xy_we      = 1'b0;
    xy_raddr   = j[AW-1:0];
    lbl_we     = 1'b0;
    lbl_waddr  = i[AW-1:0];
    lbl_wdata  = LW'(cur + 1'b1);
    lbl_raddr  = i[AW-1:0];
    mark_we    = 1'b0;
    mark_waddr = j[AW-1:0];
    mark_wdata = cur;
    seed_we    = 1'b0;
    seed_raddr = k[AW-1:0];
    case (state)
      dbc_pkg::ST_CLEAR: begin
        lbl_we     = 1'b1;
        lbl_waddr  = clr;
        lbl_wdata  = dbc_pkg::LABEL_NONE;
        mark_we    = 1'b1;
        mark_waddr = clr;
        mark_wdata = dbc_pkg::LABEL_NONE;
      end
      dbc_pkg::ST_IDLE: begin
        xy_we     = accept && items.data.op == dbc_pkg::OP_LOAD && idx_ok;
        lbl_raddr = idx_addr;
      end
      dbc_pkg::ST_RUN_NEXT: begin
        xy_raddr = i[AW-1:0];
      end
      dbc_pkg::ST_SW_ADDR: begin
        if (sweep_end && mode == dbc_pkg::SW_COUNT && ctx == dbc_pkg::CTX_OUTER) begin
          lbl_we    = 1'b1;
          lbl_wdata = core ? LW'(cur + 1'b1) : dbc_pkg::LABEL_NOISE;
        end
      end
      dbc_pkg::ST_SW_CMP: begin
        if (near && mode == dbc_pkg::SW_ADD && !mark_hit) begin
          mark_we = 1'b1;
          seed_we = 1'b1;
        end
      end
      dbc_pkg::ST_SEED_Q: begin
        xy_raddr  = seed_rd;
        lbl_raddr = seed_rd;
      end
      dbc_pkg::ST_SEED_L: begin
        lbl_waddr = q;
        lbl_wdata = cur;
        lbl_we    = (lbl_rd == dbc_pkg::LABEL_NONE) || (lbl_rd == dbc_pkg::LABEL_NOISE);
      end
      dbc_pkg::ST_NZ_ADDR: begin
        lbl_raddr = j[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dbc_pkg::ST_CLEAR;
      clr         <= '0;
      run_pend    <= 1'b0;
      out_valid   <= 1'b0;
      eps_squared <= dbc_pkg::EPS_RESET;
      core_min    <= dbc_pkg::MINP_RESET;
      point_count <= dbc_pkg::NPTS_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          dbc_pkg::CFG_EPS:    eps_squared <= cfg.data;
          dbc_pkg::CFG_MINP:   core_min    <= cfg.data[dbc_pkg::CNT_W-1:0];
          dbc_pkg::CFG_NPOINT: point_count <= cfg.data[dbc_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        dbc_pkg::ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (state_next != dbc_pkg::ST_CLEAR) begin
            run_pend <= 1'b0;
          end
        end
        dbc_pkg::ST_IDLE: begin
          if (accept && items.data.op == dbc_pkg::OP_RUN) begin
            run_pend <= 1'b1;
            clr      <= '0;
          end
        end
        dbc_pkg::ST_READ, dbc_pkg::ST_FINISH: out_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dbc_pkg::ST_IDLE: begin
        rd_ok <= idx_ok;
        if (accept && items.data.op == dbc_pkg::OP_RUN) begin
          n_r   <= (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
          i     <= '0;
          cur   <= '0;
          noise <= '0;
        end
      end
      dbc_pkg::ST_READ: begin
        // noise is stored as all ones; cluster numbers are unsigned
        if (!rd_ok) begin
          out_data.label <= '0;
        end else if (lbl_rd == dbc_pkg::LABEL_NOISE) begin
          out_data.label <= '1;
        end else begin
          out_data.label <= {1'b0, lbl_rd};
        end
        out_data.cluster_count <= '0;
        out_data.noise_count   <= '0;
      end
      dbc_pkg::ST_FINISH: begin
        out_data.label         <= '0;
        out_data.cluster_count <= cur;
        out_data.noise_count   <= dbc_pkg::CNT_W'(noise);
      end
      dbc_pkg::ST_RUN_NEXT: begin
        j <= '0;
      end
      dbc_pkg::ST_RUN_LBL: begin
        if (lbl_rd != dbc_pkg::LABEL_NONE) begin
          i <= i + 1'b1;
        end else begin
          px   <= x_rd;
          py   <= y_rd;
          ctx  <= dbc_pkg::CTX_OUTER;
          mode <= dbc_pkg::SW_COUNT;
          j    <= '0;
          cnt  <= '0;
        end
      end
      dbc_pkg::ST_SW_ADDR: begin
        if (sweep_end && mode == dbc_pkg::SW_COUNT) begin
          if (ctx == dbc_pkg::CTX_OUTER) begin
            if (core) begin
              cur    <= cur + 1'b1;
              scount <= '0;
              k      <= '0;
              mode   <= dbc_pkg::SW_ADD;
              j      <= '0;
            end else begin
              i <= i + 1'b1;
            end
          end else if (core) begin
            mode <= dbc_pkg::SW_ADD;
            j    <= '0;
          end
        end
      end
      dbc_pkg::ST_SW_DATA: begin
        dx       <= {px[15], px} - {x_rd[15], x_rd};
        dy       <= {py[15], py} - {y_rd[15], y_rd};
        mark_hit <= (mark_rd == cur);
      end
      dbc_pkg::ST_SW_SQ2: begin
        sq1 <= sq;
      end
      dbc_pkg::ST_SW_CMP: begin
        if (near && mode == dbc_pkg::SW_COUNT) begin
          cnt <= cnt + 1'b1;
        end
        if (near && mode == dbc_pkg::SW_ADD && !mark_hit) begin
          scount <= scount + 1'b1;
        end
        j <= j + 1'b1;
      end
      dbc_pkg::ST_SEED_NEXT: begin
        if (k == scount) begin
          i <= i + 1'b1;
        end
      end
      dbc_pkg::ST_SEED_Q: begin
        q <= seed_rd;
        k <= k + 1'b1;
      end
      dbc_pkg::ST_SEED_L: begin
        if (lbl_rd == dbc_pkg::LABEL_NONE) begin
          px   <= x_rd;
          py   <= y_rd;
          ctx  <= dbc_pkg::CTX_SEED;
          mode <= dbc_pkg::SW_COUNT;
          j    <= '0;
          cnt  <= '0;
        end
      end
      dbc_pkg::ST_NZ_DATA: begin
        if (lbl_rd == dbc_pkg::LABEL_NOISE) begin
          noise <= noise + 1'b1;
        end
        j <= j + 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> state == dbc_pkg::ST_IDLE)
    else $error("input ready outside idle");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    accept && items.data.op == dbc_pkg::OP_RUN |=> state == dbc_pkg::ST_CLEAR)
    else $error("run word did not start clearing pass");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == dbc_pkg::ST_READ
                          || $past(state) == dbc_pkg::ST_FINISH)
    else $error("result word from unexpected state");

  a_seed_bound: assert property (@(posedge clk) disable iff (rst)
    state == dbc_pkg::ST_SEED_NEXT |-> scount <= n_r && k <= scount)
    else $error("seed list overran point count");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for density_clustering_2d, with a scoreboard fed by
// its own clustering model. Depends on dbc_pkg, dbc_chan_if, dbc_cfg_if and density_clustering_2d.
module tb;
  import dbc_pkg::*;

  localparam int NPTS = 1024;
  localparam int NOISE = -1;

  typedef struct {
    bit               is_cfg;
    cfg_idx_t         reg_idx;
    logic [EPS_W-1:0] reg_val;
    in_word_t         w;
    bit               typed;
    out_word_t        e;
  } row_t;

  logic clk;
  logic rst;

  dbc_chan_if #(.payload_t(in_word_t))  items_if();
  dbc_chan_if #(.payload_t(out_word_t)) res_if();
  dbc_cfg_if                            cfg_if();

  density_clustering_2d uut (
    .clk(clk), .rst(rst), .items(items_if), .results(res_if), .cfg(cfg_if)
  );

  // clustering model state
  int               xs [NPTS];
  int               ys [NPTS];
  int               lbl [NPTS];
  int               seeds [NPTS];
  bit               in_seeds [NPTS];
  int               seed_n;
  logic [EPS_W-1:0] m_eps;
  int               m_minp;
  int               m_npts;

  out_word_t label_q[$];
  int        errors;
  int        burst_left;
  int        n_results;
  int        hold_left;
  bit        held;
  int        rx_mode;
  int        rx_mode_left;
  row_t      dir_tab[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("density_clustering_2d test failed");
    $finish;
  end

  function automatic bit near(int a, int b);
    longint dx, dy;
    dx = longint'(xs[a]) - longint'(xs[b]);
    dy = longint'(ys[a]) - longint'(ys[b]);
    return (dx * dx + dy * dy) <= longint'({31'b0, m_eps});
  endfunction

  function automatic int count_near(int p, int n);
    int c;
    c = 0;
    for (int i = 0; i < n; i++) if (near(p, i)) c++;
    return c;
  endfunction

  function automatic void add_near(int p, int n);
    for (int i = 0; i < n; i++) begin
      if (near(p, i) && !in_seeds[i] && seed_n < NPTS) begin
        in_seeds[i] = 1'b1;
        seeds[seed_n] = i;
        seed_n++;
      end
    end
  endfunction

  function automatic void cluster_points(output int clusters, output int noise);
    int n, cur, q;
    n = (m_npts > NPTS) ? NPTS : m_npts;
    cur = 0;
    foreach (lbl[i]) lbl[i] = 0;
    for (int i = 0; i < n; i++) begin
      if (lbl[i] != 0) continue;
      if (count_near(i, n) < m_minp) begin
        lbl[i] = NOISE;
        continue;
      end
      cur++;
      lbl[i] = cur;
      foreach (in_seeds[k]) in_seeds[k] = 1'b0;
      seed_n = 0;
      add_near(i, n);
      for (int j = 0; j < seed_n; j++) begin
        q = seeds[j];
        if (q == i) continue;
        if (lbl[q] == NOISE) begin
          lbl[q] = cur;
          continue;
        end
        if (lbl[q] != 0) continue;
        lbl[q] = cur;
        if (count_near(q, n) >= m_minp) add_near(q, n);
      end
    end
    clusters = cur;
    noise = 0;
    for (int i = 0; i < n; i++) if (lbl[i] == NOISE) noise++;
  endfunction

  function automatic bit predict_word(in_word_t w, output out_word_t e);
    int c, nz;
    e = '0;
    case (w.op)
      OP_LOAD: begin
        xs[w.index] = int'(w.x_coord);
        ys[w.index] = int'(w.y_coord);
        return 1'b0;
      end
      OP_RUN: begin
        cluster_points(c, nz);
        e.cluster_count = c[CNT_W-1:0];
        e.noise_count = nz[CNT_W-1:0];
        return 1'b1;
      end
      OP_READ: begin
        e.label = lbl[w.index][11:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_word_t mk_item(op_t op, int idx, int x, int y);
    in_word_t w;
    w.op = op;
    w.index = idx[9:0];
    w.x_coord = x[15:0];
    w.y_coord = y[15:0];
    return w;
  endfunction

  function automatic row_t item_row(op_t op, int idx, int x, int y);
    row_t r;
    r = '{default: '0};
    r.w = mk_item(op, idx, x, y);
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_idx_t i, logic [EPS_W-1:0] v);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = i;
    r.reg_val = v;
    return r;
  endfunction

  function automatic row_t typed_row(op_t op, int idx, int lab, int cc, int nc);
    row_t r;
    r = item_row(op, idx, 0, 0);
    r.typed = 1'b1;
    r.e.label = lab[11:0];
    r.e.cluster_count = cc[CNT_W-1:0];
    r.e.noise_count = nc[CNT_W-1:0];
    return r;
  endfunction

  task automatic push_word(in_word_t w, bit typed, out_word_t te);
    out_word_t pe;
    bit has;
    items_if.valid <= 1'b1;
    items_if.data <= w;
    do @(posedge clk); while (!items_if.ready);
    has = predict_word(w, pe);
    if (has) label_q.push_back(typed ? te : pe);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic wait_idle();
    items_if.valid <= 1'b0;
    while (label_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t i, logic [EPS_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= i;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (i)
      CFG_EPS:    m_eps = v;
      CFG_MINP:   m_minp = int'(v[CNT_W-1:0]);
      CFG_NPOINT: m_npts = int'(v[CNT_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side: scoreboard and stall pattern
  always @(posedge clk) begin
    out_word_t e;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (label_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %p", $time, res_if.data);
        end else begin
          e = label_q.pop_front();
          if (res_if.data.label !== e.label) begin
            errors++;
            $display("%0t: label expected %0d actual %0d", $time, e.label,
                     res_if.data.label);
          end
          if (res_if.data.cluster_count !== e.cluster_count) begin
            errors++;
            $display("%0t: cluster_count expected %0d actual %0d", $time,
                     e.cluster_count, res_if.data.cluster_count);
          end
          if (res_if.data.noise_count !== e.noise_count) begin
            errors++;
            $display("%0t: noise_count expected %0d actual %0d", $time,
                     e.noise_count, res_if.data.noise_count);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!held && n_results >= 40) begin
        held = 1'b1;
        hold_left = 400;
        res_if.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(16, 96);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          default: res_if.ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  initial begin
    int sent, cx[3], cy[3], k, idx, x, y;
    row_t r;
    out_word_t none;
    none = '0;
    errors = 0;
    n_results = 0;
    hold_left = 0;
    held = 1'b0;
    rx_mode = 0;
    rx_mode_left = 0;
    burst_left = 0;
    foreach (lbl[i]) lbl[i] = 0;
    m_eps = EPS_RESET;
    m_minp = int'(MINP_RESET);
    m_npts = int'(NPTS_RESET);
    items_if.valid = 1'b0;
    items_if.data = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_EPS;
    cfg_if.data = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // every point defined before any run touches it
    for (int i = 0; i < NPTS; i++)
      push_word(mk_item(OP_LOAD, i, $urandom, $urandom), 1'b0, none);

    dir_tab.push_back(typed_row(OP_READ, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(OP_READ, 1023, 0, 0, 0));
    dir_tab.push_back(item_row(OP_LOAD, 0, -32768, -32768));
    dir_tab.push_back(item_row(OP_LOAD, 1, 32767, 32767));
    dir_tab.push_back(item_row(OP_LOAD, 2, 0, 0));
    dir_tab.push_back(item_row(OP_LOAD, 3, 0, 0));
    dir_tab.push_back(item_row(op_t'(3), 5, 1, 1));
    dir_tab.push_back(cfg_row(CFG_NPOINT, '0));
    dir_tab.push_back(typed_row(OP_RUN, 0, 0, 0, 0));
    dir_tab.push_back(cfg_row(CFG_NPOINT, EPS_W'(4)));
    dir_tab.push_back(cfg_row(CFG_EPS, '0));
    dir_tab.push_back(cfg_row(CFG_MINP, EPS_W'(1)));
    dir_tab.push_back(item_row(OP_RUN, 0, 0, 0));
    dir_tab.push_back(item_row(OP_READ, 3, 0, 0));
    dir_tab.push_back(typed_row(OP_READ, 1000, 0, 0, 0));
    dir_tab.push_back(cfg_row(CFG_EPS, 33'h1_FFFF_FFFF));
    dir_tab.push_back(cfg_row(CFG_MINP, '0));
    dir_tab.push_back(item_row(OP_RUN, 0, 0, 0));
    dir_tab.push_back(item_row(OP_READ, 1, 0, 0));
    dir_tab.push_back(cfg_row(CFG_EPS, 33'd8589672449));
    dir_tab.push_back(item_row(OP_RUN, 0, 0, 0));
    dir_tab.push_back(cfg_row(CFG_MINP, EPS_W'(1024)));
    dir_tab.push_back(typed_row(OP_RUN, 0, 0, 0, 4));
    dir_tab.push_back(typed_row(OP_READ, 0, NOISE, 0, 0));

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.is_cfg) begin
        wait_idle();
        write_reg(r.reg_idx, r.reg_val);
      end else begin
        push_word(r.w, r.typed, r.e);
      end
    end

    sent = 0;
    while (sent < 200) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: write_reg(CFG_EPS, '0);
        1: write_reg(CFG_EPS, 33'h1_FFFF_FFFF);
        2: write_reg(CFG_EPS, EPS_W'({$urandom, $urandom}));
        default: begin
          k = $urandom_range(0, 400);
          write_reg(CFG_EPS, EPS_W'(k * k));
        end
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_MINP, '0);
        1: write_reg(CFG_MINP, EPS_W'(1));
        2: write_reg(CFG_MINP, EPS_W'(1024));
        3: write_reg(CFG_MINP, EPS_W'(2047));
        default: write_reg(CFG_MINP, EPS_W'($urandom_range(2, 6)));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_NPOINT, '0);
        1: write_reg(CFG_NPOINT, EPS_W'($urandom_range(49, 64)));
        default: write_reg(CFG_NPOINT, EPS_W'($urandom_range(1, 48)));
      endcase
      for (int c = 0; c < 3; c++) begin
        cx[c] = $urandom_range(0, 40000) - 20000;
        cy[c] = $urandom_range(0, 40000) - 20000;
      end
      for (int n = 0; n < 40; n++) begin
        k = $urandom_range(0, 99);
        idx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
        if (k < 46) begin
          if ($urandom_range(0, 9) < 7) begin
            c_pick: begin
              int c;
              c = $urandom_range(0, 2);
              x = cx[c] + $urandom_range(0, 512) - 256;
              y = cy[c] + $urandom_range(0, 512) - 256;
            end
          end else begin
            x = $urandom;
            y = $urandom;
          end
          push_word(mk_item(OP_LOAD, idx, x, y), 1'b0, none);
          sent++;
        end else if (k < 92) begin
          push_word(mk_item(OP_READ, idx, $urandom, $urandom), 1'b0, none);
          sent++;
        end else if (k < 96) begin
          push_word(mk_item(OP_RUN, $urandom, $urandom, $urandom), 1'b0, none);
          sent++;
        end else begin
          push_word(mk_item(op_t'(3), idx, $urandom, $urandom), 1'b0, none);
        end
      end
    end

    // one full-size run, point count saturating
    wait_idle();
    write_reg(CFG_EPS, '0);
    write_reg(CFG_MINP, EPS_W'(2047));
    write_reg(CFG_NPOINT, EPS_W'(2047));
    push_word(mk_item(OP_RUN, 0, 0, 0), 1'b0, none);
    push_word(mk_item(OP_READ, 1023, 0, 0), 1'b0, none);

    items_if.valid <= 1'b0;
    while (label_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("density_clustering_2d test passed");
    end else begin
      $display("density_clustering_2d test failed");
    end
    $finish;
  end

endmodule

### density_clustering_2d.f
design/dbc_pkg.sv
design/dbc_chan_if.sv
design/dbc_cfg_if.sv
design/dbc_ram.sv
design/dbc_sq.sv
design/density_clustering_2d.sv
tb/tb.sv
